[design/pctm_pkg.sv]
// ----------------------------------------------------------------------------
// pctm_pkg
// Shared widths, types and codes of the three-mode PID controller.
// ----------------------------------------------------------------------------
`default_nettype none
package pctm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ERR_BITS    = SAMPLE_BITS + 2;
  localparam int WEIGHT_BITS = 16;
  localparam int GAIN_BITS   = 24;
  localparam int LIMIT_BITS  = 31;
  localparam int BAND_BITS   = 17;
  localparam int MUL_A_BITS  = 33;
  localparam int MUL_B_BITS  = GAIN_BITS + 1;
  localparam int MUL_P_BITS  = MUL_A_BITS + MUL_B_BITS;
  localparam int DIV_N_BITS  = BAND_BITS + WEIGHT_BITS;
  localparam int DIV_C_BITS  = 6;

  typedef enum logic [1:0] {
    MODE_POS  = 2'd0,
    MODE_INC  = 2'd1,
    MODE_VAR  = 2'd2,
    MODE_HOLD = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE       = 3'd0,
    REG_KP         = 3'd1,
    REG_KI         = 3'd2,
    REG_KD         = 3'd3,
    REG_OUT_LIMIT  = 3'd4,
    REG_INT_LIMIT  = 3'd5,
    REG_BAND_HIGH  = 3'd6,
    REG_BAND_LOW   = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage
`default_nettype wire

[design/pctm_if.sv]
// ----------------------------------------------------------------------------
// pctm_in_if / pctm_out_if
// Valid/ready channels for samples and for controller results.
// ----------------------------------------------------------------------------
`default_nettype none
interface pctm_in_if;
  logic                                     valid;
  logic                                     ready;
  logic                                     kind;
  logic signed [pctm_pkg::SAMPLE_BITS-1:0]  measured;
  logic signed [pctm_pkg::SAMPLE_BITS-1:0]  target;
  logic        [pctm_pkg::SAMPLE_BITS-1:0]  wrap_period;
  modport source (output valid, kind, measured, target, wrap_period, input ready);
  modport sink   (input valid, kind, measured, target, wrap_period, output ready);
endinterface

interface pctm_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] drive;
  modport source (output valid, drive, input ready);
  modport sink   (input valid, drive, output ready);
endinterface
`default_nettype wire

[design/pctm_mul.sv]
// ----------------------------------------------------------------------------
// pctm_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none
module pctm_mul (
  input  wire logic                                   clk,
  input  wire logic signed [pctm_pkg::MUL_A_BITS-1:0] a,
  input  wire logic signed [pctm_pkg::MUL_B_BITS-1:0] b,
  output logic signed [pctm_pkg::MUL_P_BITS-1:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

[design/pctm_div.sv]
// ----------------------------------------------------------------------------
// pctm_div
// Restoring divider, one quotient bit per cycle, for the integral weight.
// ----------------------------------------------------------------------------
`default_nettype none
module pctm_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic [pctm_pkg::DIV_N_BITS-1:0]      num,
  input  wire logic [pctm_pkg::BAND_BITS-1:0]       den,
  output pctm_pkg::div_status_t                     status,
  output logic [pctm_pkg::BAND_BITS-1:0]            quot
);
  logic [pctm_pkg::DIV_N_BITS-1:0] num_r;
  logic [pctm_pkg::BAND_BITS-1:0]  quot_r;
  logic [pctm_pkg::BAND_BITS-1:0]  den_r, rem_r;
  logic [pctm_pkg::DIV_C_BITS-1:0] cnt_r;
  logic                            busy_r, done_r;
  logic [pctm_pkg::BAND_BITS:0]    trial, diff;

  always_comb begin
    trial = {rem_r, num_r[pctm_pkg::DIV_N_BITS-1]};
    diff  = trial - {1'b0, den_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= pctm_pkg::DIV_C_BITS'(pctm_pkg::DIV_N_BITS);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == pctm_pkg::DIV_C_BITS'(1)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r  <= num;
      den_r  <= den;
      rem_r  <= '0;
      quot_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[pctm_pkg::DIV_N_BITS-2:0], 1'b0};
      if (!diff[pctm_pkg::BAND_BITS]) begin
        rem_r  <= diff[pctm_pkg::BAND_BITS-1:0];
        quot_r <= {quot_r[pctm_pkg::BAND_BITS-2:0], 1'b1};
      end else begin
        rem_r  <= trial[pctm_pkg::BAND_BITS-1:0];
        quot_r <= {quot_r[pctm_pkg::BAND_BITS-2:0], 1'b0};
      end
    end
  end

  assign status = {busy_r, done_r};
  assign quot   = quot_r;
endmodule
`default_nettype wire

[design/pid_controller_three_mode.sv]
// ----------------------------------------------------------------------------
// pid_controller_three_mode
// Three-mode PID controller with wrap correction of the feedback sample.
// ----------------------------------------------------------------------------
// A positional or incremental sample runs the wrap, error, integral,
// proportional and derivative steps, then finishes. A variable-integral
// sample also weights its integral, waiting for the 33-step restoring
// divider when the weight must be divided but not when it is zero or one.
// A hold step runs only the wrap and error steps; a clear just finishes.
// All products go through one registered multiplier under a small sequencer,
// and the block takes no new sample until the current one has been handed
// to the result register, so a stalled result channel stalls the input too.
// ----------------------------------------------------------------------------
`default_nettype none
module pid_controller_three_mode (
  input  wire logic        clk,
  input  wire logic        rst_n,
  pctm_in_if.sink          in_ch,
  pctm_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);
  localparam int ACC_BITS = 60;
  localparam int EB = pctm_pkg::ERR_BITS;

  typedef enum logic [9:0] {
    S_IDLE = 10'b0000000001,
    S_WRAP = 10'b0000000010,
    S_ERR  = 10'b0000000100,
    S_MI   = 10'b0000001000,
    S_AI   = 10'b0000010000,
    S_AP   = 10'b0000100000,
    S_AD   = 10'b0001000000,
    S_WDIV = 10'b0010000000,
    S_AW   = 10'b0100000000,
    S_FIN  = 10'b1000000000
  } state_t;

  typedef enum logic [1:0] {
    W_ZERO = 2'd0,
    W_ONE  = 2'd1,
    W_DIV  = 2'd2
  } wsel_t;

  function automatic logic signed [31:0] clamp_mag(input logic signed [ACC_BITS-1:0] v,
                                                   input logic [pctm_pkg::LIMIT_BITS-1:0] lim);
    logic signed [ACC_BITS-1:0] l;
    l = $signed({{(ACC_BITS-pctm_pkg::LIMIT_BITS){1'b0}}, lim});
    if (v > l) clamp_mag = 32'(l);
    else if (v < -l) clamp_mag = 32'(-l);
    else clamp_mag = 32'(v);
  endfunction

  // Configuration registers.
  pctm_pkg::mode_t                   mode_r;
  logic [pctm_pkg::GAIN_BITS-1:0]    kp_r, ki_r, kd_r;
  logic [pctm_pkg::LIMIT_BITS-1:0]   out_limit_r, int_limit_r;
  logic [pctm_pkg::BAND_BITS-1:0]    band_high_r, band_low_r;
  pctm_pkg::reg_idx_t                cfg_idx;
  logic                              cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = pctm_pkg::reg_idx_t'(cfg_paddr[4:2]);
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= pctm_pkg::MODE_POS;
      kp_r        <= '0;
      ki_r        <= '0;
      kd_r        <= '0;
      out_limit_r <= '0;
      int_limit_r <= '0;
      band_high_r <= '0;
      band_low_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        pctm_pkg::REG_MODE:      mode_r      <= pctm_pkg::mode_t'(cfg_pwdata[1:0]);
        pctm_pkg::REG_KP:        kp_r        <= cfg_pwdata[23:0];
        pctm_pkg::REG_KI:        ki_r        <= cfg_pwdata[23:0];
        pctm_pkg::REG_KD:        kd_r        <= cfg_pwdata[23:0];
        pctm_pkg::REG_OUT_LIMIT: out_limit_r <= cfg_pwdata[30:0];
        pctm_pkg::REG_INT_LIMIT: int_limit_r <= cfg_pwdata[30:0];
        pctm_pkg::REG_BAND_HIGH: band_high_r <= cfg_pwdata[16:0];
        pctm_pkg::REG_BAND_LOW:  band_low_r  <= cfg_pwdata[16:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      pctm_pkg::REG_MODE:      cfg_prdata = {30'd0, mode_r};
      pctm_pkg::REG_KP:        cfg_prdata = {8'd0, kp_r};
      pctm_pkg::REG_KI:        cfg_prdata = {8'd0, ki_r};
      pctm_pkg::REG_KD:        cfg_prdata = {8'd0, kd_r};
      pctm_pkg::REG_OUT_LIMIT: cfg_prdata = {1'b0, out_limit_r};
      pctm_pkg::REG_INT_LIMIT: cfg_prdata = {1'b0, int_limit_r};
      pctm_pkg::REG_BAND_HIGH: cfg_prdata = {15'd0, band_high_r};
      pctm_pkg::REG_BAND_LOW:  cfg_prdata = {15'd0, band_low_r};
      default:                 cfg_prdata = '0;
    endcase
  end

  // Sequencer and datapath registers.
  state_t                                 state_r;
  logic                                   clr_r, out_valid_r;
  logic signed [31:0]                     drive_r, held_r, integ_r;
  logic signed [EB-1:0]                   el_r, ebl_r, e_r, meas_adj_r;
  logic signed [EB:0]                     d1_r;
  logic signed [EB+1:0]                   d2_r;
  logic [pctm_pkg::BAND_BITS-1:0]         mag_r;
  wsel_t                                  wsel_r;
  logic signed [pctm_pkg::SAMPLE_BITS-1:0] meas_r, targ_r;
  logic [pctm_pkg::SAMPLE_BITS-1:0]       period_r;
  logic signed [ACC_BITS-1:0]             acc_r;

  logic                                   in_xfer, fin_go;
  logic signed [pctm_pkg::MUL_A_BITS-1:0] mul_a;
  logic signed [pctm_pkg::MUL_B_BITS-1:0] mul_b;
  logic signed [pctm_pkg::MUL_P_BITS-1:0] prod;
  logic                                   div_start;
  pctm_pkg::div_status_t                  div_st;
  logic [pctm_pkg::BAND_BITS-1:0]         quot;
  logic [pctm_pkg::BAND_BITS-1:0]         weight;
  logic                                   w_ready;

  logic signed [pctm_pkg::SAMPLE_BITS:0]  gap;
  logic signed [EB-1:0]                   twice_gap, per_s;
  logic signed [EB:0]                     e_wide;
  logic signed [ACC_BITS-1:0]             int_sum, fin_sum;

  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == S_IDLE);
  assign fin_go      = !out_valid_r || out_ch.ready;
  assign out_ch.valid = out_valid_r;
  assign out_ch.drive = drive_r;

  assign div_start = (state_r == S_AI) && (mode_r == pctm_pkg::MODE_VAR) && (wsel_r == W_DIV);
  assign w_ready   = (wsel_r != W_DIV) || div_st.done;

  always_comb begin
    unique case (wsel_r)
      W_ZERO:  weight = '0;
      W_ONE:   weight = pctm_pkg::BAND_BITS'(1 << pctm_pkg::WEIGHT_BITS);
      default: weight = quot;
    endcase
  end

  pctm_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod)
  );

  pctm_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    ({band_high_r - mag_r, pctm_pkg::WEIGHT_BITS'(0)}),
    .den    (band_high_r - band_low_r),
    .status (div_st),
    .quot   (quot)
  );

  always_comb begin
    mul_a = pctm_pkg::MUL_A_BITS'(e_r);
    mul_b = $signed({1'b0, ki_r});
    unique case (state_r)
      S_AI: begin
        mul_a = (mode_r == pctm_pkg::MODE_INC) ? pctm_pkg::MUL_A_BITS'(d1_r)
                                               : pctm_pkg::MUL_A_BITS'(e_r);
        mul_b = $signed({1'b0, kp_r});
      end
      S_AP: begin
        mul_a = (mode_r == pctm_pkg::MODE_INC) ? pctm_pkg::MUL_A_BITS'(d2_r)
                                               : pctm_pkg::MUL_A_BITS'(d1_r);
        mul_b = $signed({1'b0, kd_r});
      end
      S_WDIV: begin
        mul_a = pctm_pkg::MUL_A_BITS'(integ_r);
        mul_b = $signed({{(pctm_pkg::MUL_B_BITS-pctm_pkg::BAND_BITS){1'b0}}, weight});
      end
      default: ;
    endcase
  end

  always_comb begin
    gap       = (pctm_pkg::SAMPLE_BITS+1)'(targ_r) - (pctm_pkg::SAMPLE_BITS+1)'(meas_r);
    twice_gap = EB'(gap) <<< 1;
    per_s     = $signed({2'b00, period_r});
    e_wide    = (EB+1)'(targ_r) - (EB+1)'(meas_adj_r);
    if (mode_r == pctm_pkg::MODE_INC) int_sum = ACC_BITS'(prod);
    else int_sum = ACC_BITS'(integ_r) + ACC_BITS'(prod);
    if (mode_r == pctm_pkg::MODE_VAR) fin_sum = acc_r;
    else fin_sum = acc_r + ACC_BITS'(integ_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      held_r      <= '0;
      integ_r     <= '0;
      el_r        <= '0;
      ebl_r       <= '0;
    end else begin
      if ((state_r == S_FIN) && fin_go) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) state_r <= in_ch.kind ? S_FIN : S_WRAP;
        end
        S_WRAP: state_r <= S_ERR;
        S_ERR:  state_r <= (mode_r == pctm_pkg::MODE_HOLD) ? S_FIN : S_MI;
        S_MI:   state_r <= S_AI;
        S_AI: begin
          integ_r <= clamp_mag(int_sum, int_limit_r);
          state_r <= S_AP;
        end
        S_AP:   state_r <= S_AD;
        S_AD:   state_r <= (mode_r == pctm_pkg::MODE_VAR) ? S_WDIV : S_FIN;
        S_WDIV: if (w_ready) state_r <= S_AW;
        S_AW:   state_r <= S_FIN;
        S_FIN: begin
          if (fin_go) begin
            state_r     <= S_IDLE;
            if (clr_r) begin
              held_r  <= '0;
              integ_r <= '0;
              el_r    <= '0;
              ebl_r   <= '0;
            end else begin
              if (mode_r != pctm_pkg::MODE_HOLD) held_r <= clamp_mag(fin_sum, out_limit_r);
              ebl_r <= el_r;
              el_r  <= e_r;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      clr_r    <= in_ch.kind;
      meas_r   <= in_ch.measured;
      targ_r   <= in_ch.target;
      period_r <= in_ch.wrap_period;
    end
    if (state_r == S_WRAP) begin
      if ((period_r != '0) && (twice_gap > per_s)) meas_adj_r <= EB'(meas_r) + per_s;
      else if ((period_r != '0) && (twice_gap < -per_s)) meas_adj_r <= EB'(meas_r) - per_s;
      else meas_adj_r <= EB'(meas_r);
    end
    if (state_r == S_ERR) begin
      e_r   <= EB'(e_wide);
      mag_r <= pctm_pkg::BAND_BITS'(e_wide[EB] ? -e_wide : e_wide);
      d1_r  <= e_wide - (EB+1)'(el_r);
      d2_r  <= (EB+2)'(e_wide) - ((EB+2)'(el_r) <<< 1) + (EB+2)'(ebl_r);
    end
    if (state_r == S_MI) begin
      if (mag_r > band_high_r) wsel_r <= W_ZERO;
      else if (mag_r < band_low_r) wsel_r <= W_ONE;
      else if (band_high_r == band_low_r) wsel_r <= W_ZERO;
      else wsel_r <= W_DIV;
    end
    unique case (state_r)
      S_AI: acc_r <= (mode_r == pctm_pkg::MODE_INC) ? ACC_BITS'(held_r) : '0;
      S_AP: acc_r <= acc_r + ACC_BITS'(prod);
      S_AD: acc_r <= acc_r + ACC_BITS'(prod);
      S_AW: acc_r <= acc_r + ACC_BITS'(prod >>> pctm_pkg::WEIGHT_BITS);
      default: ;
    endcase
    if ((state_r == S_FIN) && fin_go) begin
      if (clr_r) drive_r <= '0;
      else if (mode_r == pctm_pkg::MODE_HOLD) drive_r <= held_r;
      else drive_r <= clamp_mag(fin_sum, out_limit_r);
    end
  end

  // The band-selected weight must be settled before the integral is weighted.
  a_rise_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result appeared without a finishing step");

  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_st.busy)
    else $error("divider still running while idle");

  a_weight_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_AW) |-> $past(w_ready))
    else $error("integral weighted before the weight was ready");

  a_held_limit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && !clr_r && (mode_r != pctm_pkg::MODE_HOLD) |->
      (drive_r <= $signed({1'b0, out_limit_r})) && (drive_r >= -$signed({1'b0, out_limit_r})))
    else $error("drive outside the output limit");
endmodule
`default_nettype wire

[test/tb_pid_controller_three_mode.sv]
// ----------------------------------------------------------------------------
// tb_pid_controller_three_mode
// Self-checking testbench of the three-mode PID controller. A directed table
// covers the sample extremes, wrap correction and clear. It is followed by
// random phases over every mode and band case, register extremes and random
// stalls on both channels. Results are compared with the table or predictor.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_pid_controller_three_mode;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [4:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  pctm_in_if  in_ch ();
  pctm_out_if out_ch ();

  pid_controller_three_mode DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch.sink),
    .out_ch     (out_ch.source),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  typedef struct {
    logic               kind;
    logic signed [15:0] measured;
    logic signed [15:0] target;
    logic        [15:0] wrap_period;
    bit                 typed;
    logic        [31:0] drive;
  } sample_row_t;

  typedef struct {
    bit          typed;
    logic [31:0] drive;
  } typed_drive_t;

  // Predictor copies of registers and state.
  pctm_pkg::mode_t cur_mode;
  longint gain_p, gain_i, gain_d, lim_out, lim_int, band_hi, band_lo;
  longint err_last, err_prev, integ_sum, drive_held;

  logic [31:0]  drive_q[$];
  typed_drive_t typed_q[$];
  int           mismatches;
  int           items_sent;
  int           results_seen;
  int           clears_sent;
  bit           idle_en;
  bit           stall_req;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #(12 * 2000000);
    $display("Mismatches found");
    $finish;
  end

  function automatic longint clamp_mag(longint v, longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic logic [31:0] predict_drive(logic kind, logic signed [15:0] measured,
                                                logic signed [15:0] target,
                                                logic [15:0] wrap_period);
    longint meas, targ, per, gap, e, mag, w;
    meas = measured;
    targ = target;
    per  = wrap_period;
    if (kind) begin
      err_last = 0;
      err_prev = 0;
      integ_sum = 0;
      drive_held = 0;
      return 32'd0;
    end
    gap = targ - meas;
    if (per != 0) begin
      if (2 * gap > per) meas = meas + per;
      else if (2 * gap < -per) meas = meas - per;
    end
    e = targ - meas;
    mag = (e < 0) ? -e : e;
    unique case (cur_mode)
      pctm_pkg::MODE_POS: begin
        integ_sum = clamp_mag(integ_sum + gain_i * e, lim_int);
        drive_held = clamp_mag(gain_p * e + integ_sum + gain_d * (e - err_last), lim_out);
      end
      pctm_pkg::MODE_INC: begin
        integ_sum = clamp_mag(gain_i * e, lim_int);
        drive_held = clamp_mag(drive_held + gain_p * (e - err_last) + integ_sum
                               + gain_d * (e - 2 * err_last + err_prev), lim_out);
      end
      pctm_pkg::MODE_VAR: begin
        if (mag > band_hi) w = 0;
        else if (mag < band_lo) w = 64'sd65536;
        else if (band_hi == band_lo) w = 0;
        else w = ((band_hi - mag) <<< 16) / (band_hi - band_lo);
        integ_sum = clamp_mag(integ_sum + gain_i * e, lim_int);
        drive_held = clamp_mag(gain_p * e + ((w * integ_sum) >>> 16)
                               + gain_d * (e - err_last), lim_out);
      end
      default: ;
    endcase
    err_prev = err_last;
    err_last = e;
    return drive_held[31:0];
  endfunction

  task automatic report_mismatch(string msg);
    mismatches++;
    $display("%s", msg);
  endtask

  // Input transfers queue an expected drive, result transfers check it.
  always @(posedge clk) begin
    logic [31:0]  want;
    typed_drive_t td;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (drive_q.size() == 0) begin
          report_mismatch($sformatf("result transfer with nothing expected, drive %0d",
                                    $signed(out_ch.drive)));
        end else begin
          want = drive_q.pop_front();
          if (out_ch.drive !== want)
            report_mismatch($sformatf("drive mismatch at result %0d: got %0d, expected %0d",
                                      results_seen, $signed(out_ch.drive), $signed(want)));
        end
        results_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        td = typed_q.pop_front();
        want = predict_drive(in_ch.kind, in_ch.measured, in_ch.target, in_ch.wrap_period);
        drive_q.push_back(td.typed ? td.drive : want);
      end
    end
  end

  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      if (stall_req) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        stall_req = 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic cfg_write(pctm_pkg::reg_idx_t idx, logic [31:0] value);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= 5'(idx) << 2;
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    unique case (idx)
      pctm_pkg::REG_MODE:      cur_mode = pctm_pkg::mode_t'(value[1:0]);
      pctm_pkg::REG_KP:        gain_p = value[23:0];
      pctm_pkg::REG_KI:        gain_i = value[23:0];
      pctm_pkg::REG_KD:        gain_d = value[23:0];
      pctm_pkg::REG_OUT_LIMIT: lim_out = value[30:0];
      pctm_pkg::REG_INT_LIMIT: lim_int = value[30:0];
      pctm_pkg::REG_BAND_HIGH: band_hi = value[16:0];
      default:                 band_lo = value[16:0];
    endcase
  endtask

  task automatic cfg_all(pctm_pkg::mode_t m, logic [31:0] kp, logic [31:0] ki,
                         logic [31:0] kd, logic [31:0] olim, logic [31:0] ilim,
                         logic [31:0] bh, logic [31:0] bl);
    cfg_write(pctm_pkg::REG_MODE, 32'(m));
    cfg_write(pctm_pkg::REG_KP, kp);
    cfg_write(pctm_pkg::REG_KI, ki);
    cfg_write(pctm_pkg::REG_KD, kd);
    cfg_write(pctm_pkg::REG_OUT_LIMIT, olim);
    cfg_write(pctm_pkg::REG_INT_LIMIT, ilim);
    cfg_write(pctm_pkg::REG_BAND_HIGH, bh);
    cfg_write(pctm_pkg::REG_BAND_LOW, bl);
  endtask

  task automatic send_sample(sample_row_t row);
    typed_drive_t td;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    td.typed = row.typed;
    td.drive = row.drive;
    typed_q.push_back(td);
    in_ch.valid       <= 1'b1;
    in_ch.kind        <= row.kind;
    in_ch.measured    <= row.measured;
    in_ch.target      <= row.target;
    in_ch.wrap_period <= row.wrap_period;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    if (row.kind) clears_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    while (results_seen < items_sent) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  function automatic sample_row_t random_sample(int band_scale);
    sample_row_t r;
    int sel;
    r.typed = 1'b0;
    r.drive = '0;
    r.kind = ($urandom_range(0, 29) == 0);
    r.measured = 16'($urandom);
    sel = $urandom_range(0, 9);
    if (sel < 7)
      r.target = r.measured + 16'($urandom_range(0, 2 * band_scale) - band_scale);
    else
      r.target = 16'($urandom);
    sel = $urandom_range(0, 2);
    if (sel == 0) r.wrap_period = '0;
    else if (sel == 1) r.wrap_period = 16'($urandom);
    else r.wrap_period = 16'($urandom_range(1, 4 * band_scale));
    return r;
  endfunction

  sample_row_t directed_rows[13] = '{
    '{1'b0,      16'sd0,      16'sd0, 16'd0,     1'b1, 32'd0},
    '{1'b0, -16'sd32768,  16'sd32767, 16'd0,     1'b1, 32'h7FFF_FFFF},
    '{1'b0,  16'sd32767, -16'sd32768, 16'd0,     1'b1, 32'h8000_0001},
    '{1'b0,      16'sd0,    16'sd100, 16'd200,   1'b1, 32'd6553600},
    '{1'b0,      16'sd0,    16'sd101, 16'd200,   1'b1, -32'sd6488064},
    '{1'b0,      16'sd0,   -16'sd100, 16'd200,   1'b1, -32'sd6553600},
    '{1'b0,     16'sd10,      16'sd5, 16'd0,     1'b1, -32'sd327680},
    '{1'b1,      16'sd7,      16'sd9, 16'd3,     1'b1, 32'd0},
    '{1'b0, -16'sd32768,  16'sd32767, 16'd65535, 1'b1, 32'd0},
    '{1'b0,  16'sd32767, -16'sd32768, 16'd65535, 1'b1, 32'd0},
    '{1'b0, -16'sd32768,  16'sd32767, 16'd1,     1'b1, 32'h7FFF_FFFF},
    '{1'b0,      16'sd1,      16'sd0, 16'd0,     1'b1, -32'sd65536},
    '{1'b0,    -16'sd5,     16'sd3, 16'd0,       1'b1, 32'd524288}
  };

  initial begin
    sample_row_t row;
    int scale;
    pctm_pkg::mode_t m;
    rst_n       <= 1'b0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    in_ch.valid       <= 1'b0;
    in_ch.kind        <= 1'b0;
    in_ch.measured    <= '0;
    in_ch.target      <= '0;
    in_ch.wrap_period <= '0;
    cur_mode = pctm_pkg::MODE_POS;
    gain_p = 0; gain_i = 0; gain_d = 0; lim_out = 0; lim_int = 0; band_hi = 0; band_lo = 0;
    err_last = 0; err_prev = 0; integ_sum = 0; drive_held = 0;
    mismatches = 0; items_sent = 0; results_seen = 0; clears_sent = 0;
    idle_en = 1'b1;
    stall_req = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Unit proportional gain only, so each drive is the error in Q16.16.
    cfg_all(pctm_pkg::MODE_POS, 32'h1_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 0);
    foreach (directed_rows[i]) send_sample(directed_rows[i]);
    wait_drained();

    for (int phase = 0; phase < 12; phase++) begin
      scale = 2000;
      m = pctm_pkg::mode_t'($urandom_range(0, 2));
      unique case (phase)
        0: cfg_all(pctm_pkg::MODE_POS, $urandom_range(0, 1 << 18), $urandom_range(0, 1 << 16),
                   $urandom_range(0, 1 << 16), $urandom_range(1 << 28, 32'h7FFF_FFFF),
                   $urandom_range(1 << 26, 1 << 30), 500, 100);
        1: cfg_all(pctm_pkg::MODE_INC, $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 14),
                   $urandom_range(0, 1 << 14), $urandom_range(1 << 28, 32'h7FFF_FFFF),
                   $urandom_range(1 << 20, 1 << 30), 500, 100);
        2: cfg_all(pctm_pkg::MODE_VAR, $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 18),
                   $urandom_range(0, 1 << 16), 32'h7FFF_FFFF,
                   $urandom_range(1 << 24, 32'h7FFF_FFFF), 1500, 300);
        3: begin
          scale = 40;
          cfg_all(pctm_pkg::MODE_VAR, $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 18),
                  $urandom_range(0, 1 << 16), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 20, 20);
        end
        4: cfg_all(pctm_pkg::MODE_VAR, $urandom_range(0, 1 << 16), $urandom_range(0, 1 << 18),
                   $urandom_range(0, 1 << 16), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 300, 900);
        5: cfg_all(pctm_pkg::MODE_HOLD, $urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom, $urandom);
        6: cfg_all(pctm_pkg::MODE_POS, 0, 0, 0, 0, 0, 0, 0);
        7: begin
          scale = 32767;
          cfg_all(pctm_pkg::MODE_INC, 32'hFF_FFFF, 32'hFF_FFFF, 32'hFF_FFFF, 32'h7FFF_FFFF,
                  32'h7FFF_FFFF, 32'h1_FFFF, 32'h1_FFFF);
        end
        8: begin
          stall_req = 1'b1;
          cfg_all(m, $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 16),
                  $urandom_range(0, 1 << 16), $urandom_range(1 << 20, 32'h7FFF_FFFF),
                  $urandom_range(1 << 20, 32'h7FFF_FFFF), 1200, 200);
        end
        default: begin
          if (phase >= 10) idle_en = 1'b0;
          cfg_all(pctm_pkg::mode_t'($urandom_range(0, 3)), $urandom_range(0, 1 << 18),
                  $urandom_range(0, 1 << 17), $urandom_range(0, 1 << 17),
                  $urandom_range(0, 32'h7FFF_FFFF), $urandom_range(0, 32'h7FFF_FFFF),
                  $urandom_range(0, 3000), $urandom_range(0, 3000));
        end
      endcase
      for (int n = 0; n < 45; n++) begin
        row = random_sample(scale);
        send_sample(row);
      end
      wait_drained();
    end

    $display("Covered %0d samples (%0d clears) over every mode, wrap and band case,",
             items_sent, clears_sent);
    $display("with register extremes, a long result stall and random idling.");
    if (mismatches == 0 && drive_q.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
design/pctm_pkg.sv
design/pctm_if.sv
design/pctm_mul.sv
design/pctm_div.sv
design/pid_controller_three_mode.sv
test/tb_pid_controller_three_mode.sv
